/* design/mpt_pkg.sv */
`default_nettype none

package mpt_pkg;

   // Request codes carried on req_type.
   localparam logic [2:0] REQ_CLEAR = 3'd0;
   localparam logic [2:0] REQ_ADD   = 3'd1;
   localparam logic [2:0] REQ_END   = 3'd2;
   localparam logic [2:0] REQ_BUILD = 3'd3;
   localparam logic [2:0] REQ_MATCH = 3'd4;

   // Response status codes.
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_NODE_FULL     = 3'd1;
   localparam logic [2:0] ST_PATTERN_FULL  = 3'd2;
   localparam logic [2:0] ST_NOT_BUILT     = 3'd3;
   localparam logic [2:0] ST_ALREADY_BUILT = 3'd4;

   // Multipliers of the edge slot hash.
   localparam logic [31:0] HASH_MUL_NODE = 32'd2654435761;
   localparam logic [31:0] HASH_MUL_CHAR = 32'd40503;

   // Datapath micro-operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLR_START,
      OP_CLR_STEP,
      OP_ADD_INIT,
      OP_MATCH_INIT,
      OP_HASH_START,
      OP_PROBE_INIT,
      OP_PROBE_READ,
      OP_PROBE_NEXT,
      OP_ADD_HIT,
      OP_ADD_NEW,
      OP_WALK_CHILD,
      OP_FAIL_READ,
      OP_WALK_FAIL,
      OP_CURSOR_ROOT,
      OP_END_READ,
      OP_END_WRITE,
      OP_MASK_READ_WALK,
      OP_MATCH_DONE,
      OP_BUILD_INIT,
      OP_DEQ_READ,
      OP_DEQ_TAKE,
      OP_SCAN_READ,
      OP_SCAN_TAKE,
      OP_LINK_WRITE,
      OP_MASK_READ_V,
      OP_MASK_MERGE,
      OP_SCAN_NEXT,
      OP_BUILD_DONE,
      OP_RESP
   } dp_op_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_CLR,
      S_IDLE,
      S_DISP,
      S_HASH,
      S_HWAIT,
      S_PREAD,
      S_PCHK,
      S_WFAIL,
      S_NS_DONE,
      S_M_DONE,
      S_END_WR,
      S_B_DEQ,
      S_B_TAKE,
      S_B_SREAD,
      S_B_SCHK,
      S_B_FAIL,
      S_B_MV,
      S_B_MERGE,
      S_B_SNEXT,
      S_RESP
   } ctrl_state_type;

   // Which sequence called the edge lookup.
   typedef enum logic [1:0] {
      CTX_ADD,
      CTX_MATCH,
      CTX_BUILD
   } call_ctx_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] code;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       built;
      logic       pc_full;
      logic       node_full;
      logic       hash_done;
      logic       e_valid;
      logic       e_match;
      logic       probe_last;
      logic       walk_root;
      logic       clr_last;
      logic       q_empty;
      logic       s_child;
      logic       u_root;
      logic       scan_last;
      logic       out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* design/mpt_hash.sv */
`default_nettype none

module mpt_hash #(
   parameter int NODE_W    = 10,
   parameter int CHAR_BITS = 16,
   parameter int SLOT_W    = 11,
   parameter int EDGE_SLOTS = 2048
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NODE_W-1:0] parent,
   input  wire logic [CHAR_BITS-1:0] ch,
   output logic                   done,
   output logic [SLOT_W-1:0]      slot
);
   import mpt_pkg::*;

   // Divisor and its truncated reciprocal scaled by 2^32.
   localparam logic [31:0] MODULUS = 32'(EDGE_SLOTS);
   localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(EDGE_SLOTS));

   logic [31:0]       prod_a_ff, prod_a_in;
   logic [31:0]       prod_b_ff, prod_b_in;
   logic [31:0]       word_ff, word_in;
   logic [31:0]       quot_ff, quot_in;
   logic [31:0]       rem_ff, rem_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [3:0]        stage_ff, stage_in;
   logic              done_ff, done_in;
   logic [63:0]       recip_prod;

   // Four stages: combine the products, estimate the quotient by the reciprocal,
   // take the partial remainder, then one compare and subtract. The estimate is
   // at most one short, so the partial remainder is below twice the divisor.
   always_comb begin
      prod_a_in  = prod_a_ff;
      prod_b_in  = prod_b_ff;
      word_in    = word_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      slot_in    = slot_ff;
      stage_in   = {stage_ff[2:0], 1'b0};
      done_in    = done_ff;
      recip_prod = {32'd0, word_ff} * {32'd0, RECIP};
      if (stage_ff[0]) begin
         word_in = prod_a_ff ^ prod_b_ff;
      end
      if (stage_ff[1]) begin
         quot_in = recip_prod[63:32];
      end
      if (stage_ff[2]) begin
         rem_in = word_ff - quot_ff * MODULUS;
      end
      if (stage_ff[3]) begin
         if (rem_ff >= MODULUS) begin
            slot_in = SLOT_W'(rem_ff - MODULUS);
         end else begin
            slot_in = SLOT_W'(rem_ff);
         end
         done_in = 1'b1;
      end
      if (start) begin
         prod_a_in = 32'(parent) * HASH_MUL_NODE;
         prod_b_in = 32'(ch) * HASH_MUL_CHAR;
         stage_in  = 4'b0001;
         done_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      word_ff   <= word_in;
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      slot_ff   <= slot_in;
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

`default_nettype wire

/* design/mpt_datapath.sv */
`default_nettype none

module mpt_datapath #(
   parameter int MAX_NODES    = 1024,
   parameter int EDGE_SLOTS   = 2048,
   parameter int MAX_PATTERNS = 32,
   parameter int CHAR_BITS    = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mpt_pkg::dp_cmd_type    cmd,
   output mpt_pkg::dp_status_type      status,
   input  wire logic [2:0]             req_type,
   input  wire logic [15:0]            req_char_code,
   input  wire logic                   req_text_start,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [4:0]                  rsp_pattern_id,
   output logic [31:0]                 rsp_node_mask,
   output logic [31:0]                 rsp_seen_mask
);
   import mpt_pkg::*;

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int NC_W   = $clog2(MAX_NODES + 1);
   localparam int SLOT_W = $clog2(EDGE_SLOTS);
   localparam int PC_W   = $clog2(MAX_PATTERNS + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(EDGE_SLOTS - 1);

   typedef struct packed {
      logic                 valid;
      logic [NODE_W-1:0]    parent;
      logic [CHAR_BITS-1:0] ch;
      logic [NODE_W-1:0]    child;
   } edge_entry_type;

   // Memories.
   edge_entry_type    edge_mem  [EDGE_SLOTS];
   logic [NODE_W-1:0] fail_mem  [MAX_NODES];
   logic [31:0]       mask_mem  [MAX_NODES];
   logic [NODE_W-1:0] queue_mem [MAX_NODES];

   edge_entry_type    edge_rd_ff;
   logic [NODE_W-1:0] fail_rd_ff;
   logic [31:0]       mask_rd_ff;
   logic [NODE_W-1:0] queue_rd_ff;

   logic              edge_we, edge_re, fail_we, fail_re, mask_we, mask_re, queue_we, queue_re;
   logic [SLOT_W-1:0] edge_waddr, edge_raddr;
   edge_entry_type    edge_wdata;
   logic [NODE_W-1:0] fail_waddr, fail_raddr, fail_wdata;
   logic [NODE_W-1:0] mask_waddr, mask_raddr;
   logic [31:0]       mask_wdata;
   logic [NODE_W-1:0] queue_waddr, queue_raddr, queue_wdata;

   // Control registers.
   logic [NC_W-1:0]   node_count_ff, node_count_in;
   logic [PC_W-1:0]   pattern_count_ff, pattern_count_in;
   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [NODE_W-1:0] match_ff, match_in;
   logic [31:0]       acc_ff, acc_in;
   logic              built_ff, built_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [2:0]           req_type_ff, req_type_in;
   logic [CHAR_BITS-1:0] ch_ff, ch_in;
   logic                 start_ff, start_in;
   logic [NODE_W-1:0]    walk_ff, walk_in;
   logic [CHAR_BITS-1:0] probe_ch_ff, probe_ch_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [SLOT_W-1:0]    probe_n_ff, probe_n_in;
   logic [SLOT_W-1:0]    scan_ff, scan_in;
   logic [NODE_W-1:0]    u_ff, u_in;
   logic [NODE_W-1:0]    v_ff, v_in;
   logic [NC_W-1:0]      head_ff, head_in;
   logic [NC_W-1:0]      tail_ff, tail_in;
   logic [31:0]          mask_a_ff, mask_a_in;
   logic [4:0]           res_pid_ff, res_pid_in;
   logic [31:0]          res_nmask_ff, res_nmask_in;
   logic [31:0]          res_smask_ff, res_smask_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [4:0]           rsp_pid_ff, rsp_pid_in;
   logic [31:0]          rsp_nmask_ff, rsp_nmask_in;
   logic [31:0]          rsp_smask_ff, rsp_smask_in;

   logic                 hash_start, hash_done;
   logic [SLOT_W-1:0]    hash_slot;
   logic [6:0]           pc_ext;
   logic [31:0]          pat_bit;

   mpt_hash #(
      .NODE_W     (NODE_W),
      .CHAR_BITS  (CHAR_BITS),
      .SLOT_W     (SLOT_W),
      .EDGE_SLOTS (EDGE_SLOTS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .parent (walk_ff),
      .ch     (probe_ch_ff),
      .done   (hash_done),
      .slot   (hash_slot)
   );

   assign hash_start = (cmd.op == OP_HASH_START);
   assign pc_ext     = 7'(pattern_count_ff);
   assign pat_bit    = (pc_ext < 7'd32) ? (32'd1 << pc_ext[4:0]) : 32'd0;

   // Status flags for the controller.
   always_comb begin
      status.req_type   = req_type_ff;
      status.built      = built_ff;
      status.pc_full    = 32'(pattern_count_ff) >= MAX_PATTERNS;
      status.node_full  = (32'(node_count_ff) >= MAX_NODES) ||
                          (32'(node_count_ff) - 32'd1 >= EDGE_SLOTS);
      status.hash_done  = hash_done;
      status.e_valid    = edge_rd_ff.valid;
      status.e_match    = (edge_rd_ff.parent == walk_ff) && (edge_rd_ff.ch == probe_ch_ff);
      status.probe_last = (probe_n_ff == LAST_SLOT);
      status.walk_root  = (walk_ff == '0);
      status.clr_last   = (clr_ff == LAST_SLOT);
      status.q_empty    = (head_ff == tail_ff);
      status.s_child    = edge_rd_ff.valid && (edge_rd_ff.parent == u_ff);
      status.u_root     = (u_ff == '0);
      status.scan_last  = (scan_ff == LAST_SLOT);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Register updates and memory ports for each micro-operation.
   always_comb begin
      node_count_in    = node_count_ff;
      pattern_count_in = pattern_count_ff;
      cursor_in        = cursor_ff;
      match_in         = match_ff;
      acc_in           = acc_ff;
      built_in         = built_ff;
      clr_in           = clr_ff;
      req_type_in      = req_type_ff;
      ch_in            = ch_ff;
      start_in         = start_ff;
      walk_in          = walk_ff;
      probe_ch_in      = probe_ch_ff;
      slot_in          = slot_ff;
      probe_n_in       = probe_n_ff;
      scan_in          = scan_ff;
      u_in             = u_ff;
      v_in             = v_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      mask_a_in        = mask_a_ff;
      res_pid_in       = res_pid_ff;
      res_nmask_in     = res_nmask_ff;
      res_smask_in     = res_smask_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_pid_in       = rsp_pid_ff;
      rsp_nmask_in     = rsp_nmask_ff;
      rsp_smask_in     = rsp_smask_ff;
      rsp_valid_in     = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;

      edge_we     = 1'b0;
      edge_re     = 1'b0;
      edge_waddr  = slot_ff;
      edge_raddr  = slot_ff;
      edge_wdata  = '0;
      fail_we     = 1'b0;
      fail_re     = 1'b0;
      fail_waddr  = v_ff;
      fail_raddr  = walk_ff;
      fail_wdata  = walk_ff;
      mask_we     = 1'b0;
      mask_re     = 1'b0;
      mask_waddr  = v_ff;
      mask_raddr  = walk_ff;
      mask_wdata  = '0;
      queue_we    = 1'b0;
      queue_re    = 1'b0;
      queue_waddr = tail_ff[NODE_W-1:0];
      queue_raddr = head_ff[NODE_W-1:0];
      queue_wdata = v_ff;

      case (cmd.op)
         OP_ACCEPT: begin
            req_type_in  = req_type;
            ch_in        = req_char_code[CHAR_BITS-1:0];
            start_in     = req_text_start;
            res_pid_in   = '0;
            res_nmask_in = '0;
            res_smask_in = '0;
         end
         OP_CLR_START: begin
            node_count_in    = NC_W'(1);
            pattern_count_in = '0;
            cursor_in        = '0;
            match_in         = '0;
            acc_in           = '0;
            built_in         = 1'b0;
            clr_in           = '0;
         end
         OP_CLR_STEP: begin
            // Wipe one edge slot; the root's entries go with the first slot.
            edge_we    = 1'b1;
            edge_waddr = clr_ff;
            edge_wdata = '0;
            if (clr_ff == '0) begin
               mask_we    = 1'b1;
               mask_waddr = '0;
               mask_wdata = '0;
               fail_we    = 1'b1;
               fail_waddr = '0;
               fail_wdata = '0;
            end
            clr_in = clr_ff + 1'b1;
         end
         OP_ADD_INIT: begin
            walk_in     = cursor_ff;
            probe_ch_in = ch_ff;
         end
         OP_MATCH_INIT: begin
            probe_ch_in = ch_ff;
            if (start_ff) begin
               walk_in  = '0;
               match_in = '0;
               acc_in   = '0;
            end else begin
               walk_in = match_ff;
            end
         end
         OP_PROBE_INIT: begin
            slot_in    = hash_slot;
            probe_n_in = '0;
         end
         OP_PROBE_READ: begin
            edge_re    = 1'b1;
            edge_raddr = slot_ff;
         end
         OP_PROBE_NEXT: begin
            probe_n_in = probe_n_ff + 1'b1;
            slot_in    = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         end
         OP_ADD_HIT: begin
            cursor_in = edge_rd_ff.child;
         end
         OP_ADD_NEW: begin
            // The lookup stopped at the first free slot of the probe run.
            edge_we           = 1'b1;
            edge_waddr        = slot_ff;
            edge_wdata.valid  = 1'b1;
            edge_wdata.parent = walk_ff;
            edge_wdata.ch     = probe_ch_ff;
            edge_wdata.child  = node_count_ff[NODE_W-1:0];
            mask_we           = 1'b1;
            mask_waddr        = node_count_ff[NODE_W-1:0];
            mask_wdata        = '0;
            cursor_in         = node_count_ff[NODE_W-1:0];
            node_count_in     = node_count_ff + 1'b1;
         end
         OP_WALK_CHILD: begin
            walk_in = edge_rd_ff.child;
         end
         OP_FAIL_READ: begin
            fail_re    = 1'b1;
            fail_raddr = walk_ff;
         end
         OP_WALK_FAIL: begin
            walk_in = fail_rd_ff;
         end
         OP_CURSOR_ROOT: begin
            cursor_in = '0;
         end
         OP_END_READ: begin
            mask_re    = 1'b1;
            mask_raddr = cursor_ff;
         end
         OP_END_WRITE: begin
            mask_we          = 1'b1;
            mask_waddr       = cursor_ff;
            mask_wdata       = mask_rd_ff | pat_bit;
            res_pid_in       = pc_ext[4:0];
            pattern_count_in = pattern_count_ff + 1'b1;
            cursor_in        = '0;
         end
         OP_MASK_READ_WALK: begin
            mask_re    = 1'b1;
            mask_raddr = walk_ff;
         end
         OP_MATCH_DONE: begin
            match_in     = walk_ff;
            acc_in       = acc_ff | mask_rd_ff;
            res_nmask_in = mask_rd_ff;
            res_smask_in = acc_ff | mask_rd_ff;
         end
         OP_BUILD_INIT: begin
            fail_we     = 1'b1;
            fail_waddr  = '0;
            fail_wdata  = '0;
            queue_we    = 1'b1;
            queue_waddr = '0;
            queue_wdata = '0;
            head_in     = '0;
            tail_in     = NC_W'(1);
         end
         OP_DEQ_READ: begin
            queue_re    = 1'b1;
            queue_raddr = head_ff[NODE_W-1:0];
            head_in     = head_ff + 1'b1;
         end
         OP_DEQ_TAKE: begin
            u_in    = queue_rd_ff;
            scan_in = '0;
         end
         OP_SCAN_READ: begin
            edge_re    = 1'b1;
            edge_raddr = scan_ff;
         end
         OP_SCAN_TAKE: begin
            // A child of the root links to the root; others start at the parent's link.
            v_in        = edge_rd_ff.child;
            probe_ch_in = edge_rd_ff.ch;
            walk_in     = (u_ff == '0) ? '0 : u_ff;
         end
         OP_LINK_WRITE: begin
            fail_we    = 1'b1;
            fail_waddr = v_ff;
            fail_wdata = walk_ff;
            mask_re    = 1'b1;
            mask_raddr = walk_ff;
         end
         OP_MASK_READ_V: begin
            mask_a_in  = mask_rd_ff;
            mask_re    = 1'b1;
            mask_raddr = v_ff;
         end
         OP_MASK_MERGE: begin
            mask_we    = 1'b1;
            mask_waddr = v_ff;
            mask_wdata = mask_rd_ff | mask_a_ff;
            if (32'(tail_ff) < MAX_NODES) begin
               queue_we    = 1'b1;
               queue_waddr = tail_ff[NODE_W-1:0];
               queue_wdata = v_ff;
               tail_in     = tail_ff + 1'b1;
            end
         end
         OP_SCAN_NEXT: begin
            scan_in = scan_ff + 1'b1;
         end
         OP_BUILD_DONE: begin
            built_in  = 1'b1;
            cursor_in = '0;
            match_in  = '0;
            acc_in    = '0;
         end
         OP_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.code;
            rsp_pid_in    = res_pid_ff;
            rsp_nmask_in  = res_nmask_ff;
            rsp_smask_in  = res_smask_ff;
         end
         default: begin
         end
      endcase
   end

   // Memory ports with registered read data.
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      if (edge_re) begin
         edge_rd_ff <= edge_mem[edge_raddr];
      end
      if (fail_we) begin
         fail_mem[fail_waddr] <= fail_wdata;
      end
      if (fail_re) begin
         fail_rd_ff <= fail_mem[fail_raddr];
      end
      if (mask_we) begin
         mask_mem[mask_waddr] <= mask_wdata;
      end
      if (mask_re) begin
         mask_rd_ff <= mask_mem[mask_raddr];
      end
      if (queue_we) begin
         queue_mem[queue_waddr] <= queue_wdata;
      end
      if (queue_re) begin
         queue_rd_ff <= queue_mem[queue_raddr];
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff    <= NC_W'(1);
         pattern_count_ff <= '0;
         cursor_ff        <= '0;
         match_ff         <= '0;
         acc_ff           <= '0;
         built_ff         <= 1'b0;
         clr_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         node_count_ff    <= node_count_in;
         pattern_count_ff <= pattern_count_in;
         cursor_ff        <= cursor_in;
         match_ff         <= match_in;
         acc_ff           <= acc_in;
         built_ff         <= built_in;
         clr_ff           <= clr_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      ch_ff         <= ch_in;
      start_ff      <= start_in;
      walk_ff       <= walk_in;
      probe_ch_ff   <= probe_ch_in;
      slot_ff       <= slot_in;
      probe_n_ff    <= probe_n_in;
      scan_ff       <= scan_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      mask_a_ff     <= mask_a_in;
      res_pid_ff    <= res_pid_in;
      res_nmask_ff  <= res_nmask_in;
      res_smask_ff  <= res_smask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_nmask_ff  <= rsp_nmask_in;
      rsp_smask_ff  <= rsp_smask_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pattern_id = rsp_pid_ff;
   assign rsp_node_mask  = rsp_nmask_ff;
   assign rsp_seen_mask  = rsp_smask_ff;

endmodule

`default_nettype wire

/* design/mpt_ctrl.sv */
`default_nettype none

module mpt_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire mpt_pkg::dp_status_type status,
   output mpt_pkg::dp_cmd_type         cmd
);
   import mpt_pkg::*;

   ctrl_state_type state_ff, state_in;
   call_ctx_type   ctx_ff, ctx_in;
   logic [2:0]     code_ff, code_in;
   logic           clr_resp_ff, clr_resp_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         ctx_ff      <= CTX_ADD;
         code_ff     <= ST_OK;
         clr_resp_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ctx_ff      <= ctx_in;
         code_ff     <= code_in;
         clr_resp_ff <= clr_resp_in;
      end
   end

   // Next state and command.
   always_comb begin
      state_in    = state_ff;
      ctx_in      = ctx_ff;
      code_in     = code_ff;
      clr_resp_in = clr_resp_ff;
      cmd.op      = OP_NONE;
      cmd.code    = code_ff;
      req_stall   = 1'b1;

      unique case (state_ff)
         S_CLR: begin
            cmd.op = OP_CLR_STEP;
            if (status.clr_last) begin
               code_in  = ST_OK;
               state_in = clr_resp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            code_in  = ST_OK;
            state_in = S_RESP;
            case (status.req_type)
               REQ_CLEAR: begin
                  cmd.op      = OP_CLR_START;
                  clr_resp_in = 1'b1;
                  state_in    = S_CLR;
               end
               REQ_ADD: begin
                  if (status.built) begin
                     code_in = ST_ALREADY_BUILT;
                  end else begin
                     cmd.op   = OP_ADD_INIT;
                     ctx_in   = CTX_ADD;
                     state_in = S_HASH;
                  end
               end
               REQ_END: begin
                  if (status.built) begin
                     code_in = ST_ALREADY_BUILT;
                  end else if (status.pc_full) begin
                     cmd.op  = OP_CURSOR_ROOT;
                     code_in = ST_PATTERN_FULL;
                  end else begin
                     cmd.op   = OP_END_READ;
                     state_in = S_END_WR;
                  end
               end
               REQ_BUILD: begin
                  if (status.built) begin
                     code_in = ST_ALREADY_BUILT;
                  end else begin
                     cmd.op   = OP_BUILD_INIT;
                     ctx_in   = CTX_BUILD;
                     state_in = S_B_DEQ;
                  end
               end
               REQ_MATCH: begin
                  if (!status.built) begin
                     code_in = ST_NOT_BUILT;
                  end else begin
                     cmd.op   = OP_MATCH_INIT;
                     ctx_in   = CTX_MATCH;
                     state_in = S_HASH;
                  end
               end
               default: begin
               end
            endcase
         end
         // Edge lookup: hash, then probe slots until a hit, a free slot or the whole table has been probed.
         S_HASH: begin
            cmd.op   = OP_HASH_START;
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            if (status.hash_done) begin
               cmd.op   = OP_PROBE_INIT;
               state_in = S_PREAD;
            end
         end
         S_PREAD: begin
            cmd.op   = OP_PROBE_READ;
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (status.e_valid && status.e_match) begin
               if (ctx_ff == CTX_ADD) begin
                  cmd.op   = OP_ADD_HIT;
                  code_in  = ST_OK;
                  state_in = S_RESP;
               end else begin
                  cmd.op   = OP_WALK_CHILD;
                  state_in = S_NS_DONE;
               end
            end else if (!status.e_valid || status.probe_last) begin
               if (ctx_ff == CTX_ADD) begin
                  state_in = S_RESP;
                  if (status.node_full) begin
                     code_in = ST_NODE_FULL;
                  end else begin
                     cmd.op  = OP_ADD_NEW;
                     code_in = ST_OK;
                  end
               end else if (status.walk_root) begin
                  state_in = S_NS_DONE;
               end else begin
                  cmd.op   = OP_FAIL_READ;
                  state_in = S_WFAIL;
               end
            end else begin
               cmd.op   = OP_PROBE_NEXT;
               state_in = S_PREAD;
            end
         end
         S_WFAIL: begin
            cmd.op   = OP_WALK_FAIL;
            state_in = S_HASH;
         end
         S_NS_DONE: begin
            if (ctx_ff == CTX_MATCH) begin
               cmd.op   = OP_MASK_READ_WALK;
               state_in = S_M_DONE;
            end else begin
               cmd.op   = OP_LINK_WRITE;
               state_in = S_B_MV;
            end
         end
         S_M_DONE: begin
            cmd.op   = OP_MATCH_DONE;
            code_in  = ST_OK;
            state_in = S_RESP;
         end
         S_END_WR: begin
            cmd.op   = OP_END_WRITE;
            code_in  = ST_OK;
            state_in = S_RESP;
         end
         // Breadth-first pass over the trie.
         S_B_DEQ: begin
            if (status.q_empty) begin
               cmd.op   = OP_BUILD_DONE;
               code_in  = ST_OK;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_DEQ_READ;
               state_in = S_B_TAKE;
            end
         end
         S_B_TAKE: begin
            cmd.op   = OP_DEQ_TAKE;
            state_in = S_B_SREAD;
         end
         S_B_SREAD: begin
            cmd.op   = OP_SCAN_READ;
            state_in = S_B_SCHK;
         end
         S_B_SCHK: begin
            if (status.s_child) begin
               cmd.op   = OP_SCAN_TAKE;
               state_in = status.u_root ? S_NS_DONE : S_B_FAIL;
            end else if (status.scan_last) begin
               state_in = S_B_DEQ;
            end else begin
               cmd.op   = OP_SCAN_NEXT;
               state_in = S_B_SREAD;
            end
         end
         S_B_FAIL: begin
            cmd.op   = OP_FAIL_READ;
            state_in = S_WFAIL;
         end
         S_B_MV: begin
            cmd.op   = OP_MASK_READ_V;
            state_in = S_B_MERGE;
         end
         S_B_MERGE: begin
            cmd.op   = OP_MASK_MERGE;
            state_in = status.scan_last ? S_B_DEQ : S_B_SNEXT;
         end
         S_B_SNEXT: begin
            cmd.op   = OP_SCAN_NEXT;
            state_in = S_B_SREAD;
         end
         S_RESP: begin
            if (status.out_free) begin
               cmd.op      = OP_RESP;
               clr_resp_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/multi_pattern_title_matcher_unit.sv */
`default_nettype none

// Aho-Corasick multi-pattern matcher over CHAR_BITS-bit characters. Each request
// (clear, add pattern character, end pattern, build links, match character) gives
// exactly one response, and requests are taken one at a time: req_stall is low only
// while the unit is idle. After reset and on every clear request the edge table is
// swept, one slot per cycle, before the next request is taken. Every edge lookup
// runs the slot hash through its product, reciprocal, remainder and correction
// stages, then probes slots. An add character is one lookup; a match character is
// one lookup per node visited, following a failure link after each miss below the
// root. End pattern and a request refused for its order need no lookup. A new
// response waits while the previous one is still held by rsp_stall. The build pass
// reads every edge slot once for each trie node and does one failure walk for each
// edge that does not leave the root.
module multi_pattern_title_matcher_unit #(
   parameter int MAX_NODES    = 1024,
   parameter int EDGE_SLOTS   = 2048,
   parameter int MAX_PATTERNS = 32,
   parameter int CHAR_BITS    = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [15:0] req_char_code,
   input  wire logic        req_text_start,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [4:0]       rsp_pattern_id,
   output logic [31:0]      rsp_node_mask,
   output logic [31:0]      rsp_seen_mask
);
   import mpt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   mpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables, registers and the hash unit.
   mpt_datapath #(
      .MAX_NODES    (MAX_NODES),
      .EDGE_SLOTS   (EDGE_SLOTS),
      .MAX_PATTERNS (MAX_PATTERNS),
      .CHAR_BITS    (CHAR_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_text_start (req_text_start),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_pattern_id (rsp_pattern_id),
      .rsp_node_mask  (rsp_node_mask),
      .rsp_seen_mask  (rsp_seen_mask)
   );

endmodule

`default_nettype wire
